// ===== sv/ffa_pkg.sv =====
`default_nettype none
package ffa_pkg;

    localparam logic [31:0] HDR_BYTES = 32'd4;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic REG_POOL_BASE = 1'b0;
    localparam logic REG_POOL_SIZE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_F_RD,
        S_F_CHK,
        S_F_PREV,
        S_F_DEC,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        action;
        logic [31:0] req_size;
        logic [31:0] address;
    } t_req;

    typedef struct packed {
        logic [31:0] grant_address;
        logic [1:0]  status;
        logic [31:0] used_bytes;
    } t_rsp;

endpackage
`default_nettype wire

// ===== sv/first_fit_free_list_allocator_top.sv =====
`default_nettype none
// First-fit free-list allocator with coalescing.
// Request channel: i_req is sampled when start is high and busy is low. The
// block then raises busy and works on that one request alone.
// Result channel: o_rsp is valid for exactly one cycle, marked by o_done. The
// receiver cannot stall it and takes the beat in that cycle.
// Config channel: i_cfg_valid/o_cfg_ready carry index and data. Index 0 is
// pool_base and index 1 is pool_size. Any write to either one resets the free
// table to a single segment and clears the used count. Writes are accepted
// only while the block is idle.
// Sequencing: the free table is one memory with one read port and one write port,
// the port being the limit. An allocate scans the entries in turn, a read and a
// check for each; an exact fit then shifts the entries that follow down by one,
// a read and a write for each. A free scans for its place, reads the entry below
// it, then may shift entries up or down, a read and a write for each. busy is
// low again in the result cycle, so the next beat can be taken at its end.
// Reset: synchronous and active low. It empties the pool (base 0, size 0,
// one zero-size segment) and clears the used count.
module first_fit_free_list_allocator_top
    import ffa_pkg::*;
#(
    parameter int FREE_ENTRIES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_req        i_req,
    output logic             o_done,
    output t_rsp             o_rsp,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    localparam int AW = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
    localparam int CW = $clog2(FREE_ENTRIES + 1);
    localparam logic [CW-1:0] NMAX = CW'(FREE_ENTRIES);

    // Free table memory, start and size packed side by side.
    logic [63:0] mem [FREE_ENTRIES];
    logic [63:0] r_rd;
    logic        r_we;
    logic [AW-1:0] r_wa;
    logic [63:0] r_wd;
    logic [AW-1:0] n_ra;

    // Entry 0 shadow-overridden by pool config until written after config.
    logic        r_e0_cfg;
    logic [31:0] r_pool_base, r_pool_size;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [31:0]   r_used, n_used;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic          r_dir, n_dir;        // 1: shift up (insert), 0: shift down
    logic [63:0]   r_hold, n_hold;      // entry carried by an upward shift
    logic [32:0]   r_blk, n_blk;
    logic [31:0]   r_st, n_st;
    logic [63:0]   r_nxt, n_nxt;        // entry at insertion point
    logic          r_mn, n_mn;
    t_rsp          r_rsp, n_rsp;
    logic          r_done, n_done;
    logic          n_we;
    logic [AW-1:0] n_wa;
    logic [63:0]   n_wd;

    logic [63:0] rd_ent;
    logic [32:0] sum33;
    logic [33:0] sum34;
    logic [31:0] sat;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign o_done      = r_done;
    assign o_rsp       = r_rsp;

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            mem[r_wa] <= r_wd;
        end
        r_rd <= mem[n_ra];
    end

    // The read registered above could collide with a write in that cycle; the
    // sequencer never uses data read from an address in the cycle it is written.
    logic [AW-1:0] r_ra;
    always_ff @(posedge i_clk) begin
        r_ra <= n_ra;
    end
    assign rd_ent = (r_e0_cfg && r_ra == '0) ? {r_pool_base, r_pool_size} : r_rd;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_used  = r_used;
        n_i     = r_i;
        n_j     = r_j;
        n_dir   = r_dir;
        n_hold  = r_hold;
        n_blk   = r_blk;
        n_st    = r_st;
        n_nxt   = r_nxt;
        n_mn    = r_mn;
        n_rsp   = r_rsp;
        n_done  = 1'b0;
        n_we    = 1'b0;
        n_wa    = '0;
        n_wd    = '0;
        n_ra    = r_i[AW-1:0];
        sum33   = '0;
        sum34   = '0;
        sat     = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_blk = {1'b0, i_req.req_size} + 33'(HDR_BYTES);
                    n_st  = i_req.address - HDR_BYTES;
                    n_i   = '0;
                    n_ra  = '0;
                    n_state = (i_req.action == ACT_ALLOC) ? S_A_RD : S_F_RD;
                end
            end
            S_A_RD: begin
                if (r_i >= r_cnt) begin
                    n_rsp   = '{grant_address: '0, status: ST_NOFIT, used_bytes: r_used};
                    n_state = S_DONE;
                end else begin
                    n_state = S_A_CHK;
                end
            end
            S_A_CHK: begin
                if ({1'b0, rd_ent[31:0]} >= r_blk) begin
                    n_used = r_used + r_blk[31:0];
                    n_rsp  = '{grant_address: rd_ent[63:32] + HDR_BYTES,
                               status: ST_OK, used_bytes: r_used + r_blk[31:0]};
                    if (rd_ent[31:0] == r_blk[31:0]) begin
                        n_dir   = 1'b0;
                        n_j     = r_i;
                        n_cnt   = r_cnt - 1'b1;
                        n_ra    = AW'(r_i + 1'b1);
                        n_state = (r_i + 1'b1 < r_cnt) ? S_SH_RD : S_DONE;
                    end else begin
                        n_we = 1'b1;
                        n_wa = r_i[AW-1:0];
                        n_wd = {rd_ent[63:32] + r_blk[31:0], rd_ent[31:0] - r_blk[31:0]};
                        n_state = S_DONE;
                    end
                end else begin
                    n_i     = r_i + 1'b1;
                    n_ra    = AW'(r_i + 1'b1);
                    n_state = S_A_RD;
                end
            end
            S_F_RD: begin
                if (r_i >= r_cnt) begin
                    n_mn = 1'b0;
                    n_ra = AW'(r_i - 1'b1);
                    n_state = (r_i == '0) ? S_F_DEC : S_F_PREV;
                end else begin
                    n_state = S_F_CHK;
                end
            end
            S_F_CHK: begin
                if (rd_ent[63:32] <= r_st) begin
                    n_i     = r_i + 1'b1;
                    n_ra    = AW'(r_i + 1'b1);
                    n_state = S_F_RD;
                end else begin
                    n_nxt = rd_ent;
                    n_mn  = ({1'b0, rd_ent[63:32]} == {1'b0, r_st} + r_blk);
                    n_ra  = AW'(r_i - 1'b1);
                    n_state = (r_i == '0) ? S_F_DEC : S_F_PREV;
                end
            end
            S_F_PREV: begin
                // rd_ent is entry i-1
                if ({1'b0, rd_ent[63:32]} + {1'b0, rd_ent[31:0]} == {1'b0, r_st}) begin
                    n_used = r_used - r_blk[31:0];
                    n_rsp  = '{grant_address: '0, status: ST_OK,
                               used_bytes: r_used - r_blk[31:0]};
                    sum34 = {2'b0, rd_ent[31:0]} + {1'b0, r_blk}
                          + (r_mn ? {2'b0, r_nxt[31:0]} : 34'd0);
                    sat = (sum34[33:32] != 2'b0) ? 32'hFFFF_FFFF : sum34[31:0];
                    n_we = 1'b1;
                    n_wa = AW'(r_i - 1'b1);
                    n_wd = {rd_ent[63:32], sat};
                    if (r_mn) begin
                        n_dir = 1'b0;
                        n_j   = r_i;
                        n_cnt = r_cnt - 1'b1;
                        n_ra  = AW'(r_i + 1'b1);
                        n_state = (r_i + 1'b1 < r_cnt) ? S_SH_RD : S_DONE;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_F_DEC;
                end
            end
            S_F_DEC: begin
                if (r_mn) begin
                    sum33 = {1'b0, r_nxt[31:0]} + r_blk;
                    sat = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
                    n_we = 1'b1;
                    n_wa = r_i[AW-1:0];
                    n_wd = {r_st, sat};
                    n_used = r_used - r_blk[31:0];
                    n_rsp  = '{grant_address: '0, status: ST_OK,
                               used_bytes: r_used - r_blk[31:0]};
                    n_state = S_DONE;
                end else if (r_cnt >= NMAX) begin
                    n_rsp   = '{grant_address: '0, status: ST_FULL, used_bytes: r_used};
                    n_state = S_DONE;
                end else begin
                    sat = r_blk[32] ? 32'hFFFF_FFFF : r_blk[31:0];
                    n_we   = 1'b1;
                    n_wa   = r_i[AW-1:0];
                    n_wd   = {r_st, sat};
                    n_hold = r_nxt;
                    n_used = r_used - r_blk[31:0];
                    n_rsp  = '{grant_address: '0, status: ST_OK,
                               used_bytes: r_used - r_blk[31:0]};
                    n_dir  = 1'b1;
                    n_j    = r_i + 1'b1;
                    n_cnt  = r_cnt + 1'b1;
                    n_ra   = AW'(r_i + 1'b1);
                    n_state = (r_i < r_cnt) ? S_SH_RD : S_DONE;
                end
            end
            S_SH_RD: begin
                // up: j points to slot to fill with r_hold, read old j first
                // down: read j+1, write to j
                n_ra = r_dir ? r_j[AW-1:0] : AW'(r_j + 1'b1);
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                n_we = 1'b1;
                n_wa = r_j[AW-1:0];
                if (r_dir) begin
                    n_wd   = r_hold;
                    n_hold = rd_ent;
                    n_j    = r_j + 1'b1;
                    n_state = (r_j + 1'b1 < r_cnt) ? S_SH_RD : S_DONE;
                end else begin
                    n_wd = rd_ent;
                    n_j  = r_j + 1'b1;
                    n_state = (r_j + 1'b1 < r_cnt) ? S_SH_RD : S_DONE;
                end
            end
            S_DONE: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= CW'(1);
            r_used      <= '0;
            r_done      <= 1'b0;
            r_we        <= 1'b0;
            r_e0_cfg    <= 1'b1;
            r_pool_base <= '0;
            r_pool_size <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_we    <= n_we;
            if (n_we && n_wa == '0) begin
                r_e0_cfg <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_cnt    <= CW'(1);
                r_used   <= '0;
                r_e0_cfg <= 1'b1;
                if (i_cfg_index == REG_POOL_BASE) begin
                    r_pool_base <= i_cfg_data;
                end else begin
                    r_pool_size <= i_cfg_data;
                end
            end else begin
                r_cnt  <= n_cnt;
                r_used <= n_used;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wa   <= n_wa;
        r_wd   <= n_wd;
        r_i    <= n_i;
        r_j    <= n_j;
        r_dir  <= n_dir;
        r_hold <= n_hold;
        r_blk  <= n_blk;
        r_st   <= n_st;
        r_nxt  <= n_nxt;
        r_mn   <= n_mn;
        r_rsp  <= n_rsp;
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NMAX) else $error("segment count overflow");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held");
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("done while busy");
    a_nofit_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status != ST_OK) |-> $stable(r_used))
        else $error("failed request changed used count");
`endif
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import ffa_pkg::*;

    localparam int ENTRIES     = 64;
    localparam int LIMIT_CYC   = 2000000;
    localparam int DRAIN_CYC   = 600;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 185;

    typedef enum logic { ROW_REQ, ROW_CFG } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_req        req;
        logic        cfg_index;
        logic [31:0] cfg_data;
        bit          typed;
        t_rsp        rsp;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_req        i_req = '0;
    logic        o_done;
    t_rsp        o_rsp;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [31:0] i_cfg_data = '0;

    first_fit_free_list_allocator_top #(.FREE_ENTRIES(ENTRIES)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .o_done(o_done), .o_rsp(o_rsp), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the free table and pool registers
    logic [31:0] base_m, size_m;
    logic [31:0] seg_st [ENTRIES];
    logic [31:0] seg_sz [ENTRIES];
    int          seg_cnt;
    logic [31:0] used_m;

    t_rsp        pending_rsp[$];
    int          errors = 0;
    int          cycles = 0;

    // Blocks granted in the current phase, used to build legal frees
    logic [31:0] live_addr[$];
    logic [31:0] live_size[$];

    task automatic table_reinit();
        for (int k = 0; k < ENTRIES; k++) begin
            seg_st[k] = '0;
            seg_sz[k] = '0;
        end
        seg_st[0] = base_m;
        seg_sz[0] = size_m;
        seg_cnt = 1;
        used_m = '0;
        live_addr.delete();
        live_size.delete();
    endtask

    task automatic drop_seg(input int k);
        for (int j = k; j + 1 < seg_cnt; j++) begin
            seg_st[j] = seg_st[j + 1];
            seg_sz[j] = seg_sz[j + 1];
        end
        if (seg_cnt > 0) seg_cnt--;
    endtask

    function automatic logic [31:0] sat(input logic [33:0] v);
        return (v > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    // Apply one request to the shadow table and return its answer.
    task automatic alloc_free_step(input t_req r, output t_rsp p);
        logic [32:0] blk;
        logic [31:0] st0;
        logic [32:0] end33;
        int          i;
        bit          found, mp, mn;
        blk = {1'b0, r.req_size} + 33'd4;
        p = '0;
        p.status = ST_OK;
        if (r.action == ACT_ALLOC) begin
            found = 0;
            for (i = 0; i < seg_cnt && !found; i++) begin
                if ({1'b0, seg_sz[i]} >= blk) begin
                    found = 1;
                    p.grant_address = seg_st[i] + HDR_BYTES;
                    seg_sz[i] = seg_sz[i] - blk[31:0];
                    if (seg_sz[i] == 0) drop_seg(i);
                    else seg_st[i] = seg_st[i] + blk[31:0];
                    used_m = used_m + blk[31:0];
                end
            end
            if (!found) p.status = ST_NOFIT;
        end else begin
            st0 = r.address - HDR_BYTES;
            end33 = {1'b0, st0} + blk;
            i = 0;
            while (i < seg_cnt && seg_st[i] <= st0) i++;
            mp = (i > 0) && (({1'b0, seg_st[i - 1]} + seg_sz[i - 1]) == {1'b0, st0});
            mn = (i < seg_cnt) && ({1'b0, seg_st[i]} == end33);
            if (mp && mn) begin
                seg_sz[i - 1] = sat({2'b0, seg_sz[i - 1]} + blk + seg_sz[i]);
                drop_seg(i);
                used_m = used_m - blk[31:0];
            end else if (mp) begin
                seg_sz[i - 1] = sat({2'b0, seg_sz[i - 1]} + blk);
                used_m = used_m - blk[31:0];
            end else if (mn) begin
                seg_st[i] = st0;
                seg_sz[i] = sat({2'b0, seg_sz[i]} + blk);
                used_m = used_m - blk[31:0];
            end else if (seg_cnt >= ENTRIES) begin
                p.status = ST_FULL;
            end else begin
                for (int j = seg_cnt; j > i; j--) begin
                    seg_st[j] = seg_st[j - 1];
                    seg_sz[j] = seg_sz[j - 1];
                end
                seg_st[i] = st0;
                seg_sz[i] = sat({1'b0, blk});
                seg_cnt++;
                used_m = used_m - blk[31:0];
            end
        end
        p.used_bytes = used_m;
    endtask

    // Mostly short gaps, some long ones; none at all in quiet stretches.
    function automatic int pick_gap(input bit no_idle);
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Drive one request beat and wait for the block to take it.
    task automatic send_beat(input t_req r, input bit typed, input t_rsp typed_rsp,
                             input int gap);
        t_rsp p;
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        alloc_free_step(r, p);
        pending_rsp.push_back(typed ? typed_rsp : p);
        if (r.action == ACT_ALLOC && p.status == ST_OK) begin
            live_addr.push_back(p.grant_address);
            live_size.push_back(r.req_size);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Config writes only once every answer is back and the block is idle.
    task automatic cfg_write(input logic idx, input logic [31:0] data);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_rsp.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == REG_POOL_BASE) base_m = data;
        else size_m = data;
        table_reinit();
    endtask

    function automatic t_row req_row(input logic act, input logic [31:0] sz,
                                     input logic [31:0] addr);
        t_row w;
        w = '{kind: ROW_REQ, default: '0};
        w.req = '{action: act, req_size: sz, address: addr};
        return w;
    endfunction

    function automatic t_row chk_row(input logic act, input logic [31:0] sz,
                                     input logic [31:0] addr, input logic [31:0] g,
                                     input t_status s, input logic [31:0] u);
        t_row w;
        w = req_row(act, sz, addr);
        w.typed = 1;
        w.rsp = '{grant_address: g, status: s, used_bytes: u};
        return w;
    endfunction

    function automatic t_row cfg_row(input logic idx, input logic [31:0] d);
        t_row w;
        w = '{kind: ROW_CFG, default: '0};
        w.cfg_index = idx;
        w.cfg_data = d;
        return w;
    endfunction

    // Result monitor: every done beat pairs with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, o_rsp);
                errors++;
            end else begin
                t_rsp e;
                e = pending_rsp.pop_front();
                if (o_rsp.grant_address !== e.grant_address) begin
                    $display("%0t: grant_address exp %h got %h", $time,
                             e.grant_address, o_rsp.grant_address);
                    errors++;
                end
                if (o_rsp.status !== e.status) begin
                    $display("%0t: status exp %0d got %0d", $time, e.status, o_rsp.status);
                    errors++;
                end
                if (o_rsp.used_bytes !== e.used_bytes) begin
                    $display("%0t: used_bytes exp %h got %h", $time,
                             e.used_bytes, o_rsp.used_bytes);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYC) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        t_row        rows[$];
        t_req        r;
        t_rsp        none;
        logic [31:0] ph_base [RAND_PHASES];
        logic [31:0] ph_size [RAND_PHASES];
        int          pick, k;
        bit          quiet;

        none = '0;
        base_m = '0;
        size_m = '0;
        table_reinit();

        // Reset pool is empty: nothing fits, but a free can still merge.
        rows.push_back(chk_row(ACT_ALLOC, 32'h0, 32'h0, 32'h0, ST_NOFIT, 32'h0));
        rows.push_back(chk_row(ACT_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, ST_NOFIT,
                               32'h0));
        rows.push_back(req_row(ACT_FREE, 32'h0, 32'h4));
        rows.push_back(cfg_row(REG_POOL_BASE, 32'h1000));
        rows.push_back(cfg_row(REG_POOL_SIZE, 32'h100));
        rows.push_back(chk_row(ACT_ALLOC, 32'h1C, 32'h0, 32'h1004, ST_OK, 32'h20));
        // header makes this a 2^32 - 1 byte block: far too big
        rows.push_back(chk_row(ACT_ALLOC, 32'hFFFF_FFFB, 32'h0, 32'h0, ST_NOFIT, 32'h20));
        // exact fit empties the table
        rows.push_back(chk_row(ACT_ALLOC, 32'hDC, 32'h0, 32'h1024, ST_OK, 32'h100));
        rows.push_back(chk_row(ACT_ALLOC, 32'h0, 32'h0, 32'h0, ST_NOFIT, 32'h100));
        rows.push_back(req_row(ACT_FREE, 32'h1C, 32'h1004));
        rows.push_back(req_row(ACT_FREE, 32'hDC, 32'h1024));
        rows.push_back(req_row(ACT_FREE, 32'h10, 32'h2000));
        rows.push_back(cfg_row(REG_POOL_BASE, 32'hFFFF_FFF0));
        rows.push_back(cfg_row(REG_POOL_SIZE, 32'hFFFF_FFFF));
        rows.push_back(chk_row(ACT_ALLOC, 32'h10, 32'h0, 32'hFFFF_FFF4, ST_OK, 32'h14));
        // grant wraps past the top of the address space
        rows.push_back(req_row(ACT_ALLOC, 32'h0, 32'h0));
        rows.push_back(req_row(ACT_FREE, 32'h10, 32'hFFFF_FFF4));
        // saturating merge and a bogus free
        rows.push_back(req_row(ACT_FREE, 32'hFFFF_FFFB, 32'h8000_0000));
        rows.push_back(req_row(ACT_FREE, 32'h0, 32'h0));
        rows.push_back(req_row(ACT_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        rows.push_back(cfg_row(REG_POOL_SIZE, 32'h0));
        rows.push_back(chk_row(ACT_ALLOC, 32'h0, 32'h0, 32'h0, ST_NOFIT, 32'h0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[n]) begin
            if (rows[n].kind == ROW_CFG) cfg_write(rows[n].cfg_index, rows[n].cfg_data);
            else send_beat(rows[n].req, rows[n].typed, rows[n].rsp, pick_gap(0));
        end

        ph_base[0] = 32'h0;          ph_size[0] = 32'h800;
        ph_base[1] = 32'h0004_0000;  ph_size[1] = 32'h1000;
        ph_base[2] = 32'hFFFF_F800;  ph_size[2] = 32'h1000;
        ph_base[3] = $urandom;       ph_size[3] = $urandom_range(32'h100, 32'h2000);
        ph_base[4] = 32'h0;          ph_size[4] = 32'hFFFF_FFFF;
        ph_base[5] = 32'hFFFF_FFFF;  ph_size[5] = 32'h0;

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            cfg_write(REG_POOL_BASE, ph_base[ph]);
            cfg_write(REG_POOL_SIZE, ph_size[ph]);
            quiet = 0;
            for (int it = 0; it < PHASE_ITEMS; it++) begin
                if (it % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 99);
                if (pick >= 50 && pick < 90 && live_addr.size() != 0) begin
                    // well-formed free of a live block
                    k = $urandom_range(0, live_addr.size() - 1);
                    r = '{action: ACT_FREE, req_size: live_size[k], address: live_addr[k]};
                    live_addr.delete(k);
                    live_size.delete(k);
                end else if (pick >= 90) begin
                    // bogus free, near the pool or anywhere
                    r.action = ACT_FREE;
                    r.req_size = $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 64);
                    r.address = $urandom_range(0, 1) ? $urandom
                              : ph_base[ph] + $urandom_range(0, 32'h1100);
                end else begin
                    r.action = ACT_ALLOC;
                    r.req_size = $urandom_range(0, 32) == 0 ? $urandom : $urandom_range(0, 60);
                    r.address = $urandom;
                end
                send_beat(r, 0, none, pick_gap(quiet));
            end
        end

        start <= 1'b0;
        k = 0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (errors == 0 && pending_rsp.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== first_fit_free_list_allocator_top.f =====
sv/ffa_pkg.sv
sv/first_fit_free_list_allocator_top.sv
sim/tb_top.sv
